FILE: hdl/assert_macros.svh
// Assertion macros shared by the root-step RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under reset
`define NBRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication under reset
`define NBRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under reset
`define NBRS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/nbrs_pkg.sv
// Types, codes and helpers of the safeguarded Newton root-step block
package nbrs_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WAIT_A = 2'd1,
    PH_WAIT_B = 2'd2,
    PH_ITER   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MUL  = 3'd1,
    ST_CMP  = 3'd2,
    ST_DIV  = 3'd3,
    ST_NEWT = 3'd4,
    ST_BIS  = 3'd5,
    ST_FIN  = 3'd6,
    ST_PUSH = 3'd7
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_ACCEPT = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIVGO  = 3'd3,
    OP_NEWT   = 3'd4,
    OP_BIS    = 3'd5,
    OP_FIN    = 3'd6,
    OP_PUSH   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    AK_NONE   = 2'd0,
    AK_RESULT = 2'd1,
    AK_ITER   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    RS_PROBE  = 3'd0,
    RS_ROOT   = 3'd1,
    RS_LIMIT  = 3'd2,
    RS_NOBRKT = 3'd3,
    RS_NONFIN = 3'd4
  } res_e;

  typedef enum logic [2:0] {
    CFG_BRACKET_A   = 3'd0,
    CFG_BRACKET_B   = 3'd1,
    CFG_START_GUESS = 3'd2,
    CFG_MAX_ITERS   = 3'd3,
    CFG_ACCURACY    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] bracket_a;
    logic signed [31:0] bracket_b;
    logic signed [31:0] start_guess;
    logic [15:0]        max_iters;
    logic [30:0]        accuracy;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] fval;
    logic signed [31:0] dfval;
    logic               fval_ok;
    logic               dfval_ok;
  } in_t;

  typedef struct packed {
    op_e    op;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    kind_e  acc_kind;
    phase_e acc_phase;
    logic   newton_ok;
    logic   div_done;
    logic   newt_fail;
    logic   bis_stall;
    logic   fin_stop;
  } sts_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

FILE: hdl/nbrs_if.sv
// Valid/ready channel interfaces for evaluation items and results
interface nbrs_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] fval;
  logic signed [31:0] dfval;
  logic               fval_ok;
  logic               dfval_ok;

  modport source (output valid, cmd, fval, dfval, fval_ok, dfval_ok, input ready);
  modport sink   (input valid, cmd, fval, dfval, fval_ok, dfval_ok, output ready);
endinterface

interface nbrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] probe_x;
  logic [2:0]         status;
  logic [16:0]        iterations;

  modport source (output valid, probe_x, status, iterations, input ready);
  modport sink   (input valid, probe_x, status, iterations, output ready);
endinterface

FILE: hdl/nbrs_div.sv
// Iterative restoring divider for the Newton quotient, one quotient bit a cycle
`include "assert_macros.svh"
module nbrs_div import nbrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [32:0] quot_o,
  output logic        ovf_o
);

  localparam int QBITS = 33;

  logic [63:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [32:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        ovf_q, ovf_d;

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quo_q;
  assign ovf_o  = ovf_q;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      rem_d  = dividend_i;
      den_d  = {divisor_i, 32'd0};
      quo_d  = '0;
      cnt_d  = 6'(QBITS);
      busy_d = 1'b1;
      // quotient needs more than 33 bits: saturates anyway
      ovf_d  = {1'b0, dividend_i} >= {divisor_i, 33'd0};
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (rem_q >= den_q) begin
          rem_d = rem_q - den_q;
          quo_d = {quo_q[31:0], 1'b1};
        end else begin
          quo_d = {quo_q[31:0], 1'b0};
        end
        den_d = den_q >> 1;
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      den_q  <= den_d;
      quo_q  <= quo_d;
      ovf_q  <= ovf_d;
    end
  end

  `NBRS_ASSERT_IMP(a_div_no_restart, clk_i, rst_ni, start_i, !busy_q, "divider restarted while busy")
  `NBRS_ASSERT_NXT(a_div_stays_busy, clk_i, rst_ni, busy_q && (cnt_q != '0), busy_q && !done_o || busy_q && (cnt_q == '0), "divider dropped out early")
  `NBRS_ASSERT_NXT(a_div_done_once, clk_i, rst_ni, done_o && !start_i, !busy_q, "divider done held")

endmodule

FILE: hdl/nbrs_ctrl.sv
// Sequencer: solve phase, per-item step sequence and output handshake
`include "assert_macros.svh"
module nbrs_ctrl import nbrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  state_e st_q, st_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    st_d         = st_q;
    phase_d      = phase_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o.op     = OP_NONE;
    cmd_o.phase  = phase_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          phase_d  = sts_i.acc_phase;
          case (sts_i.acc_kind)
            AK_RESULT: st_d = ST_PUSH;
            AK_ITER:   st_d = ST_MUL;
            default:   st_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        st_d     = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.newton_ok) begin
          cmd_o.op = OP_DIVGO;
          st_d     = ST_DIV;
        end else begin
          st_d = ST_BIS;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) st_d = ST_NEWT;
      end
      ST_NEWT: begin
        cmd_o.op = OP_NEWT;
        st_d     = sts_i.newt_fail ? ST_BIS : ST_FIN;
      end
      ST_BIS: begin
        cmd_o.op = OP_BIS;
        if (sts_i.bis_stall) begin
          phase_d = PH_IDLE;
          st_d    = ST_PUSH;
        end else begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        phase_d  = sts_i.fin_stop ? PH_IDLE : PH_ITER;
        st_d     = ST_PUSH;
      end
      ST_PUSH: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.op    = OP_PUSH;
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  `NBRS_ASSERT_IMP(a_newt_after_div, clk_i, rst_ni, st_q == ST_NEWT, $past(st_q) == ST_DIV, "step without divide")
  `NBRS_ASSERT_IMP(a_mul_in_iter, clk_i, rst_ni, st_q == ST_MUL, phase_q == PH_ITER, "iteration step outside iterate phase")
  `NBRS_ASSERT_NXT(a_push_shows, clk_i, rst_ni, st_q == ST_PUSH && out_free, out_valid_q && st_q == ST_IDLE, "pushed result not shown")

endmodule

FILE: hdl/nbrs_dp.sv
// Datapath: bracket, step and result registers, multiply, compare and divide
module nbrs_dp import nbrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  in_t                in_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic signed [31:0] out_x_o,
  output logic [2:0]         out_st_o,
  output logic [16:0]        out_it_o
);

  localparam logic signed [31:0] I32MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] I32MIN = 32'sh80000000;

  logic signed [31:0] low_q, low_d, high_q, high_d, x_q, x_d;
  logic signed [31:0] step_q, step_d, prev_q, prev_d, fa_q, fa_d;
  logic signed [31:0] f_q, f_d, df_q, df_d;
  logic               dfok_q, dfok_d;
  logic [16:0]        it_q, it_d;
  logic [63:0]        prod_q, prod_d;
  logic signed [31:0] res_x_q, res_x_d;
  res_e               res_st_q, res_st_d;
  logic [16:0]        res_it_q, res_it_d;
  logic signed [31:0] ox_q, ox_d;
  logic [2:0]         ost_q, ost_d;
  logic [16:0]        oit_q, oit_d;

  logic signed [31:0] a, b, g;
  logic signed [32:0] sum_ab, mid, dab, nx, diff, half;
  logic [32:0]        mag_ab;
  logic [31:0]        mag_f, mag_df, mag_p, mag_step;
  logic [63:0]        lhs;
  logic               neg;
  logic signed [31:0] dx;
  logic [16:0]        jn;
  logic               div_done;
  logic [32:0]        quot;
  logic               ovf;
  logic               newt_fail;
  kind_e              acc_kind;
  phase_e             acc_phase;

  assign a = cfg_i.bracket_a;
  assign b = cfg_i.bracket_b;
  assign g = cfg_i.start_guess;

  assign mag_f    = mag32(f_q);
  assign mag_df   = mag32(df_q);
  assign mag_p    = mag32(prev_q);
  assign mag_step = mag32(step_q);
  assign lhs      = 64'(mag_f) << (FRAC_BITS + 1);

  nbrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIVGO),
    .dividend_i (64'(mag_f) << FRAC_BITS),
    .divisor_i  (mag_df),
    .done_o     (div_done),
    .quot_o     (quot),
    .ovf_o      (ovf)
  );

  always_comb begin
    sum_ab = 33'(a) + 33'(b);
    mid    = $signed(sum_ab + 33'(sum_ab[32])) >>> 1;
    dab    = 33'(b) - 33'(a);
    mag_ab = dab[32] ? 33'(-dab) : 33'(dab);
    neg    = f_q[31] ^ df_q[31];
    if (neg) dx = (ovf || quot > 33'h080000000) ? I32MIN : 32'(-quot[31:0]);
    else     dx = (ovf || quot > 33'h07FFFFFFF) ? I32MAX : $signed(quot[31:0]);
    nx     = 33'(x_q) - 33'(dx);
    diff   = 33'(high_q) - 33'(low_q);
    half   = $signed(diff + 33'(diff[32])) >>> 1;
    jn     = it_q + 17'd1;
  end

  assign newt_fail = (nx > 33'(high_q) && nx > 33'(low_q))
                  || (nx < 33'(high_q) && nx < 33'(low_q))
                  || (dx == '0);

  assign sts_o.acc_kind  = acc_kind;
  assign sts_o.acc_phase = acc_phase;
  assign sts_o.newton_ok = dfok_q && !(lhs > prod_q);
  assign sts_o.div_done  = div_done;
  assign sts_o.newt_fail = newt_fail;
  assign sts_o.bis_stall = (half == '0);
  assign sts_o.fin_stop  = (mag_step < {1'b0, cfg_i.accuracy}) || (jn > {1'b0, cfg_i.max_iters});

  always_comb begin
    low_d = low_q;  high_d = high_q; x_d = x_q;
    step_d = step_q; prev_d = prev_q; fa_d = fa_q;
    f_d = f_q; df_d = df_q; dfok_d = dfok_q; it_d = it_q;
    prod_d = prod_q;
    res_x_d = res_x_q; res_st_d = res_st_q; res_it_d = res_it_q;
    ox_d = ox_q; ost_d = ost_q; oit_d = oit_q;
    acc_kind  = AK_NONE;
    acc_phase = cmd_i.phase;

    case (cmd_i.op)
      OP_ACCEPT: begin
        f_d    = in_i.fval;
        df_d   = in_i.dfval;
        dfok_d = in_i.dfval_ok;
        acc_kind = AK_RESULT;
        res_it_d = '0;
        if (in_i.cmd == CMD_START) begin
          x_d  = ((a <= g && g <= b) || (b <= g && g <= a)) ? g : mid[31:0];
          it_d = '0;
          res_x_d = a; res_st_d = RS_PROBE;
          acc_phase = PH_WAIT_A;
        end else begin
          acc_phase = PH_IDLE;
          unique case (cmd_i.phase)
            PH_IDLE: acc_kind = AK_NONE;
            PH_WAIT_A: begin
              if (!in_i.fval_ok) begin
                res_x_d = '0; res_st_d = RS_NOBRKT;
              end else begin
                fa_d = in_i.fval;
                res_x_d = b; res_st_d = RS_PROBE;
                acc_phase = PH_WAIT_B;
              end
            end
            PH_WAIT_B: begin
              if (!in_i.fval_ok
                  || !((fa_q <= 0 && in_i.fval >= 0) || (fa_q >= 0 && in_i.fval <= 0))) begin
                res_x_d = '0; res_st_d = RS_NOBRKT;
              end else if (fa_q == 0) begin
                res_x_d = a; res_st_d = RS_ROOT;
              end else if (in_i.fval == 0) begin
                res_x_d = b; res_st_d = RS_ROOT;
              end else begin
                if (fa_q < 0) begin
                  low_d = a; high_d = b;
                end else begin
                  low_d = b; high_d = a;
                end
                prev_d = (mag_ab > 33'h07FFFFFFF) ? I32MAX : $signed(mag_ab[31:0]);
                step_d = prev_d;
                res_x_d = x_q;
                if (cfg_i.max_iters == '0) begin
                  res_st_d = RS_LIMIT; res_it_d = 17'd1;
                end else begin
                  it_d = 17'd1;
                  res_st_d = RS_PROBE;
                  acc_phase = PH_ITER;
                end
              end
            end
            PH_ITER: begin
              res_x_d  = x_q;
              res_it_d = it_q;
              if (!in_i.fval_ok) begin
                res_st_d = RS_NONFIN;
              end else if (in_i.fval == 0) begin
                res_st_d = RS_ROOT;
              end else begin
                if (in_i.fval < 0) low_d = x_q;
                else               high_d = x_q;
                acc_kind  = AK_ITER;
                acc_phase = PH_ITER;
              end
            end
            default: acc_kind = AK_NONE;
          endcase
        end
      end
      OP_MUL: prod_d = mag_p * mag_df;
      OP_NEWT: begin
        if (!newt_fail) begin
          prev_d = step_q;
          step_d = dx;
          x_d    = nx[31:0];
        end
      end
      OP_BIS: begin
        prev_d = step_q;
        step_d = half[31:0];
        x_d    = low_q + half[31:0];
        // result for when bisection no longer moves the point; OP_FIN overwrites it otherwise
        res_x_d = x_d; res_st_d = RS_ROOT; res_it_d = it_q;
      end
      OP_FIN: begin
        res_x_d = x_q;
        if (mag_step < {1'b0, cfg_i.accuracy}) begin
          res_st_d = RS_ROOT; res_it_d = it_q;
        end else if (jn > {1'b0, cfg_i.max_iters}) begin
          res_st_d = RS_LIMIT; res_it_d = jn;
        end else begin
          it_d = jn;
          res_st_d = RS_PROBE; res_it_d = '0;
        end
      end
      OP_PUSH: begin
        ox_d = res_x_q; ost_d = res_st_q; oit_d = res_it_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= '0; high_q <= '0; x_q <= '0; step_q <= '0; prev_q <= '0;
      fa_q <= '0; it_q <= '0;
    end else begin
      low_q <= low_d; high_q <= high_d; x_q <= x_d; step_q <= step_d;
      prev_q <= prev_d; fa_q <= fa_d; it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d; df_q <= df_d; dfok_q <= dfok_d; prod_q <= prod_d;
    res_x_q <= res_x_d; res_st_q <= res_st_d; res_it_q <= res_it_d;
    ox_q <= ox_d; ost_q <= ost_d; oit_q <= oit_d;
  end

  assign out_x_o  = ox_q;
  assign out_st_o = ost_q;
  assign out_it_o = oit_q;

endmodule

FILE: hdl/newton_bisection_root_step.sv
// Top level: safeguarded Newton/bisection root-step sequencer with APB config
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid/ready   | cmd, fval, dfval, fval_ok, dfval_ok
//  out_o   | out | valid/ready   | probe_x, status, iterations
//  apb     | in  | psel/penable  | paddr, pwdata, prdata (32 bit)
//
// A start item or a bracket-end answer goes straight to a result. An iteration item
// runs multiply and compare, then the restoring divider and a Newton step when one is
// tried, a bisection step when it is not or fails, and a finish step (not after a stall).
// One item is in work at a time; a waiting result does not block the next transfer in.
// Reset is asynchronous and needs no clearing pass.
module newton_bisection_root_step import nbrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nbrs_in_if.sink     in_i,
  nbrs_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_q;
  cfg_idx_e widx;
  in_t      in_pl;
  cmd_t     cmd;
  sts_t     sts;
  logic signed [31:0] out_x;
  logic [2:0]         out_st;
  logic [16:0]        out_it;

  assign pready = 1'b1;
  assign widx   = cfg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bracket_a   <= '0;
      cfg_q.bracket_b   <= 32'sd1 <<< FRAC_BITS;
      cfg_q.start_guess <= '0;
      cfg_q.max_iters   <= 16'd100;
      cfg_q.accuracy    <= 31'd16;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        CFG_BRACKET_A:   cfg_q.bracket_a   <= pwdata;
        CFG_BRACKET_B:   cfg_q.bracket_b   <= pwdata;
        CFG_START_GUESS: cfg_q.start_guess <= pwdata;
        CFG_MAX_ITERS:   cfg_q.max_iters   <= pwdata[15:0];
        CFG_ACCURACY:    cfg_q.accuracy    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      CFG_BRACKET_A:   prdata = cfg_q.bracket_a;
      CFG_BRACKET_B:   prdata = cfg_q.bracket_b;
      CFG_START_GUESS: prdata = cfg_q.start_guess;
      CFG_MAX_ITERS:   prdata = {16'd0, cfg_q.max_iters};
      CFG_ACCURACY:    prdata = {1'b0, cfg_q.accuracy};
      default:         prdata = '0;
    endcase
  end

  assign in_pl.cmd      = in_i.cmd;
  assign in_pl.fval     = in_i.fval;
  assign in_pl.dfval    = in_i.dfval;
  assign in_pl.fval_ok  = in_i.fval_ok;
  assign in_pl.dfval_ok = in_i.dfval_ok;

  nbrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  nbrs_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_pl),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .out_x_o  (out_x),
    .out_st_o (out_st),
    .out_it_o (out_it)
  );

  assign out_o.probe_x    = out_x;
  assign out_o.status     = out_st;
  assign out_o.iterations = out_it;

endmodule
